// ----- rtl/bmac_pkg.sv -----
`default_nettype none
package bmac_pkg;

  localparam int MAX_MASK_SIDE   = 64;
  localparam int MAX_FRAMES      = 8;
  localparam int MAX_SOURCE_SIDE = 1024;

  localparam int SRC_REG_W  = 11;
  localparam int MASK_REG_W = 7;
  localparam int FC_REG_W   = 4;
  localparam int POS_W      = 10;
  localparam int POS_MAX    = (1 << POS_W) - 1;

  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = REG_IDX_W + 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_MASK_WIDTH    = 3'd2,
    REG_MASK_HEIGHT   = 3'd3,
    REG_FRAME_COUNT   = 3'd4
  } reg_idx_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CUT  = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [7:0]       frame_number;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [7:0]       mask_alpha;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       was_cut;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/bilinear_mask_alpha_cutout.sv -----
`default_nettype none
// Alpha cutout by a bilinear-sampled binary mask. Load items (operation 0) write one mask
// texel and give no result. Cut items (operation 1) give one result, and the next item is
// taken the cycle after the result is registered; the result waits while the output side is
// not ready. A cut's time is set by the two bit-serial restoring dividers (one quotient bit
// per cycle over the 17-bit texel numerator, both axes side by side) and by the four reads
// through the single read port of the mask memory, one corner per cycle. The mask memory has
// no reset: a cut must only touch texels that were loaded. The user must write configuration
// registers over the APB port only while idle; the block itself does not enforce it.
module bilinear_mask_alpha_cutout
  import bmac_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int SIDE_W  = (MAX_MASK_SIDE > 1) ? $clog2(MAX_MASK_SIDE) : 1;
  localparam int SIDE_CW = $clog2(MAX_MASK_SIDE + 1);
  localparam int FR_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FC_W    = $clog2(MAX_FRAMES + 1);
  localparam int SRC_W   = $clog2(MAX_SOURCE_SIDE + 1);
  localparam int NUM_W   = $clog2((2 * POS_MAX + 1) * MAX_MASK_SIDE + 1);
  localparam int REM_W   = $clog2(2 * MAX_SOURCE_SIDE + 1);
  localparam int CNT_W   = $clog2(NUM_W + 1);
  localparam int DEPTH   = MAX_FRAMES * MAX_MASK_SIDE * MAX_MASK_SIDE;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SUB, S_DIV, S_FIN, S_READ, S_CMB, S_OUT
  } state_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [SIDE_W-1:0] lo;
    logic [SIDE_W-1:0] hi;
    logic              frac;
  } axis_t;

  function automatic div_t div_step(input logic [REM_W-1:0] rem, input logic [NUM_W-1:0] n,
                                    input logic [REM_W-1:0] d);
    logic [REM_W:0] sh;
    div_t           res;
    sh = {rem, n[NUM_W-1]};
    if (sh >= {1'b0, d}) begin
      res.rem = REM_W'(sh - {1'b0, d});
      res.quo = {n[NUM_W-2:0], 1'b1};
    end else begin
      res.rem = sh[REM_W-1:0];
      res.quo = {n[NUM_W-2:0], 1'b0};
    end
    return res;
  endfunction

  function automatic axis_t map_axis(input logic [NUM_W-1:0] q, input logic [REM_W-1:0] rem,
                                     input logic [SIDE_CW-1:0] size);
    logic [SIDE_CW-1:0] last;
    logic [SIDE_CW-1:0] lo;
    logic [SIDE_CW-1:0] lo1;
    axis_t              res;
    last = size - 1'b1;
    if (q >= NUM_W'(last)) begin
      lo       = last;
      res.frac = 1'b0;
    end else begin
      lo       = SIDE_CW'(q);
      res.frac = (rem != '0);
    end
    lo1    = lo + 1'b1;
    res.lo = SIDE_W'(lo);
    res.hi = (lo1 < last) ? SIDE_W'(lo1) : SIDE_W'(last);
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [FR_W-1:0] fr,
                                                 input logic [SIDE_W-1:0] r,
                                                 input logic [SIDE_W-1:0] c);
    return ADDR_W'((int'(fr) * MAX_MASK_SIDE + int'(r)) * MAX_MASK_SIDE + int'(c));
  endfunction

  logic [SRC_REG_W-1:0]  src_w_r, src_h_r;
  logic [MASK_REG_W-1:0] mask_w_r, mask_h_r;
  logic [FC_REG_W-1:0]   frames_r;

  logic [SRC_W-1:0]   sw_c, sh_c;
  logic [SIDE_CW-1:0] mw_c, mh_c;
  logic [FC_W-1:0]    fc_c;
  logic [REM_W-1:0]   dx, dy;

  state_t            state_r;
  in_item_t          item_r;
  logic [FR_W-1:0]   frame_r;
  logic [NUM_W-1:0]  px_r, py_r;
  logic [REM_W-1:0]  remx_r, remy_r;
  logic [CNT_W-1:0]  cnt_r;
  axis_t             ax_r, ay_r;
  logic [1:0]        k_r;
  logic              pend_r, chk_r, cut_r;
  logic              out_valid_r;
  out_item_t         out_data_r;
  logic              mem_q_r;

  logic              mem [DEPTH];
  logic              in_acc, cfg_wr, load_ok, cut_fin;
  logic [7:0]        fr_sel;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  div_t              stx, sty;
  axis_t             mx, my;

  assign pready    = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_wr    = psel && penable && pwrite;

  assign sw_c = (src_w_r == '0) ? SRC_W'(1) :
                (int'(src_w_r) > MAX_SOURCE_SIDE) ? SRC_W'(MAX_SOURCE_SIDE) : SRC_W'(src_w_r);
  assign sh_c = (src_h_r == '0) ? SRC_W'(1) :
                (int'(src_h_r) > MAX_SOURCE_SIDE) ? SRC_W'(MAX_SOURCE_SIDE) : SRC_W'(src_h_r);
  assign mw_c = (mask_w_r == '0) ? SIDE_CW'(1) :
                (int'(mask_w_r) > MAX_MASK_SIDE) ? SIDE_CW'(MAX_MASK_SIDE) : SIDE_CW'(mask_w_r);
  assign mh_c = (mask_h_r == '0) ? SIDE_CW'(1) :
                (int'(mask_h_r) > MAX_MASK_SIDE) ? SIDE_CW'(MAX_MASK_SIDE) : SIDE_CW'(mask_h_r);
  assign fc_c = (frames_r == '0) ? FC_W'(1) :
                (int'(frames_r) > MAX_FRAMES) ? FC_W'(MAX_FRAMES) : FC_W'(frames_r);
  assign dx   = REM_W'({sw_c, 1'b0});
  assign dy   = REM_W'({sh_c, 1'b0});

  assign fr_sel  = (int'(in_data.frame_number) < int'(fc_c)) ? in_data.frame_number
                                                               : 8'(fc_c - 1'b1);
  assign load_ok = (int'(in_data.frame_number) < MAX_FRAMES) &&
                   (int'(in_data.col) < MAX_MASK_SIDE) && (int'(in_data.row) < MAX_MASK_SIDE);
  assign wr_addr = mem_addr(FR_W'(in_data.frame_number), SIDE_W'(in_data.row),
                            SIDE_W'(in_data.col));
  assign rd_addr = mem_addr(frame_r, k_r[1] ? ay_r.hi : ay_r.lo, k_r[0] ? ax_r.hi : ax_r.lo);

  assign stx     = div_step(remx_r, px_r, dx);
  assign sty     = div_step(remy_r, py_r, dy);
  assign mx      = map_axis(px_r, remx_r, mw_c);
  assign my      = map_axis(py_r, remy_r, mh_c);
  assign cut_fin = cut_r && (!pend_r || !chk_r || mem_q_r);

  always_comb begin
    case (reg_idx_t'(paddr[PADDR_W-1:2]))
      REG_SOURCE_WIDTH:  prdata = 32'(src_w_r);
      REG_SOURCE_HEIGHT: prdata = 32'(src_h_r);
      REG_MASK_WIDTH:    prdata = 32'(mask_w_r);
      REG_MASK_HEIGHT:   prdata = 32'(mask_h_r);
      REG_FRAME_COUNT:   prdata = 32'(frames_r);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= SRC_REG_W'(1024);
      src_h_r  <= SRC_REG_W'(1024);
      mask_w_r <= MASK_REG_W'(64);
      mask_h_r <= MASK_REG_W'(64);
      frames_r <= FC_REG_W'(8);
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[PADDR_W-1:2]))
        REG_SOURCE_WIDTH:  src_w_r  <= pwdata[SRC_REG_W-1:0];
        REG_SOURCE_HEIGHT: src_h_r  <= pwdata[SRC_REG_W-1:0];
        REG_MASK_WIDTH:    mask_w_r <= pwdata[MASK_REG_W-1:0];
        REG_MASK_HEIGHT:   mask_h_r <= pwdata[MASK_REG_W-1:0];
        REG_FRAME_COUNT:   frames_r <= pwdata[FC_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // mask memory: 1 = clear
  always_ff @(posedge clk) begin
    if (in_acc && in_data.operation == OP_LOAD && load_ok) begin
      mem[wr_addr] <= (in_data.mask_alpha == 8'd0);
    end
    mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      pend_r <= (state_r == S_READ);
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_data.operation == OP_CUT) begin
            item_r  <= in_data;
            frame_r <= FR_W'(fr_sel);
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          px_r    <= NUM_W'({item_r.col, 1'b1}) * NUM_W'(mw_c);
          py_r    <= NUM_W'({item_r.row, 1'b1}) * NUM_W'(mh_c);
          state_r <= S_SUB;
        end
        S_SUB: begin
          px_r    <= (px_r > NUM_W'(sw_c)) ? px_r - NUM_W'(sw_c) : '0;
          py_r    <= (py_r > NUM_W'(sh_c)) ? py_r - NUM_W'(sh_c) : '0;
          remx_r  <= '0;
          remy_r  <= '0;
          cnt_r   <= CNT_W'(NUM_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          remx_r <= stx.rem;
          px_r   <= stx.quo;
          remy_r <= sty.rem;
          py_r   <= sty.quo;
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          ax_r    <= mx;
          ay_r    <= my;
          k_r     <= 2'd0;
          cut_r   <= 1'b1;
          state_r <= S_READ;
        end
        S_READ: begin
          cut_r <= cut_fin;
          chk_r <= (!k_r[0] || ax_r.frac) && (!k_r[1] || ay_r.frac);
          k_r   <= k_r + 1'b1;
          if (k_r == 2'd3) begin
            state_r <= S_CMB;
          end
        end
        S_CMB: begin
          cut_r   <= cut_fin;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r          <= 1'b1;
            out_data_r.out_red   <= item_r.red;
            out_data_r.out_green <= item_r.green;
            out_data_r.out_blue  <= item_r.blue;
            out_data_r.out_alpha <= cut_r ? 8'd0 : item_r.alpha;
            out_data_r.was_cut   <= cut_r;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bmac_checker.sv -----
`default_nettype none
module bmac_checker
  import bmac_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire in_item_t           in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire out_item_t          out_data,
  input wire logic               pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_cut_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.was_cut |-> out_data.out_alpha == 8'd0)
    else $error("cut item with nonzero alpha");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_cut_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.operation == OP_CUT |=> !in_ready && !$rose(out_valid))
    else $error("cut item finished or overlapped too early");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind bilinear_mask_alpha_cutout bmac_checker u_bmac_checker (.*);
`default_nettype wire

// ----- test/tb_bilinear_mask_alpha_cutout.sv -----
`timescale 1ns / 1ps
module tb_bilinear_mask_alpha_cutout;
  import bmac_pkg::*;

  localparam int MAP_DEPTH = MAX_FRAMES * MAX_MASK_SIDE * MAX_MASK_SIDE;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  bilinear_mask_alpha_cutout dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  in_item_t    items_to_send[$];
  out_item_t   pixels_due[$];
  bit          texel_clear [0:MAP_DEPTH-1];
  bit          texel_loaded [0:MAP_DEPTH-1];
  int unsigned src_w = 1024;
  int unsigned src_h = 1024;
  int unsigned msk_w = 64;
  int unsigned msk_h = 64;
  int unsigned frame_cnt = 8;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          n_queued = 0;
  int          n_accepted = 0;
  int          n_errors = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint used_value(input longint v, input longint hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int texel_index(input int f, input int r, input int c);
    return (f * MAX_MASK_SIDE + r) * MAX_MASK_SIDE + c;
  endfunction

  // texel-center mapping with edge clamp; frac set when the remainder is nonzero
  function automatic void map_axis(input longint pos, input longint size, input longint span,
                                   output int lo, output int hi, output bit frac);
    longint num;
    longint den;
    longint last;
    num = (2 * pos + 1) * size - span;
    den = 2 * span;
    last = size - 1;
    frac = 1'b0;
    lo = 0;
    if (num > 0) begin
      if (num / den >= last) begin
        lo = int'(last);
      end else begin
        lo = int'(num / den);
        frac = (num % den) != 0;
      end
    end
    hi = (lo + 1 < last) ? lo + 1 : int'(last);
  endfunction

  // texels with nonzero weight for a cut under the current registers
  function automatic int cut_corners(input in_item_t it, output bit [3:0][31:0] taddr);
    int frame;
    int x0;
    int x1;
    int y0;
    int y1;
    int n;
    int fc;
    bit fx;
    bit fy;
    fc = int'(used_value(frame_cnt, MAX_FRAMES));
    frame = (int'(it.frame_number) < fc) ? int'(it.frame_number) : fc - 1;
    map_axis(it.col, used_value(msk_w, MAX_MASK_SIDE), used_value(src_w, MAX_SOURCE_SIDE),
             x0, x1, fx);
    map_axis(it.row, used_value(msk_h, MAX_MASK_SIDE), used_value(src_h, MAX_SOURCE_SIDE),
             y0, y1, fy);
    taddr = '0;
    taddr[0] = texel_index(frame, y0, x0);
    n = 1;
    if (fx) begin
      taddr[n] = texel_index(frame, y0, x1);
      n = n + 1;
    end
    if (fy) begin
      taddr[n] = texel_index(frame, y1, x0);
      n = n + 1;
    end
    if (fx && fy) begin
      taddr[n] = texel_index(frame, y1, x1);
      n = n + 1;
    end
    return n;
  endfunction

  function automatic bit load_in_range(input in_item_t it);
    return it.frame_number < MAX_FRAMES && it.col < MAX_MASK_SIDE && it.row < MAX_MASK_SIDE;
  endfunction

  task automatic update_mask_or_cut(input in_item_t it);
    bit [3:0][31:0] taddr;
    int             n;
    bit             cut;
    out_item_t      px;
    if (it.operation == OP_LOAD) begin
      if (load_in_range(it))
        texel_clear[texel_index(int'(it.frame_number), int'(it.row), int'(it.col))] =
          (it.mask_alpha == 8'd0);
    end else begin
      n = cut_corners(it, taddr);
      cut = 1'b1;
      for (int i = 0; i < n; i++) cut = cut & texel_clear[taddr[i]];
      px.out_red = it.red;
      px.out_green = it.green;
      px.out_blue = it.blue;
      px.out_alpha = cut ? 8'd0 : it.alpha;
      px.was_cut = cut;
      pixels_due.push_back(px);
    end
  endtask

  task automatic check_pixel(input out_item_t got);
    out_item_t want;
    if (pixels_due.size() == 0) begin
      n_errors++;
      if (n_errors <= 10)
        $display("%0t: unexpected pixel r %0d g %0d b %0d a %0d cut %0d", $time,
                 got.out_red, got.out_green, got.out_blue, got.out_alpha, got.was_cut);
    end else begin
      want = pixels_due.pop_front();
      if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue || got.out_alpha !== want.out_alpha ||
          got.was_cut !== want.was_cut) begin
        n_errors++;
        if (n_errors <= 10)
          $display("%0t: pixel mismatch: expected r %0d g %0d b %0d a %0d cut %0d,",
                   $time, want.out_red, want.out_green, want.out_blue, want.out_alpha,
                   want.was_cut, " got r %0d g %0d b %0d a %0d cut %0d",
                   got.out_red, got.out_green, got.out_blue, got.out_alpha, got.was_cut);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        update_mask_or_cut(in_data);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= items_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_pixel(out_data);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic in_item_t rand_fields();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t rand_load();
    in_item_t it;
    int       fc;
    it = rand_fields();
    it.operation = OP_LOAD;
    it.mask_alpha = ($urandom_range(9) < 7) ? 8'd0 : 8'($urandom_range(255, 1));
    if ($urandom_range(99) < 85) begin
      fc = int'(used_value(frame_cnt, MAX_FRAMES));
      it.frame_number = 8'($urandom_range(fc - 1));
      // mostly inside the active mask, sometimes beyond it but inside the store
      if ($urandom_range(3) == 0) begin
        it.col = POS_W'($urandom_range(MAX_MASK_SIDE - 1));
        it.row = POS_W'($urandom_range(MAX_MASK_SIDE - 1));
      end else begin
        it.col = POS_W'($urandom_range(int'(used_value(msk_w, MAX_MASK_SIDE)) - 1));
        it.row = POS_W'($urandom_range(int'(used_value(msk_h, MAX_MASK_SIDE)) - 1));
      end
    end
    return it;
  endfunction

  function automatic in_item_t rand_cut();
    in_item_t it;
    it = rand_fields();
    it.operation = OP_CUT;
    if ($urandom_range(9) < 7)
      it.frame_number = 8'($urandom_range(int'(used_value(frame_cnt, MAX_FRAMES)) - 1));
    if ($urandom_range(9) < 8)
      it.col = POS_W'($urandom_range(int'(used_value(src_w, MAX_SOURCE_SIDE)) - 1));
    if ($urandom_range(9) < 8)
      it.row = POS_W'($urandom_range(int'(used_value(src_h, MAX_SOURCE_SIDE)) - 1));
    return it;
  endfunction

  // a cut is preceded by loads of any texel it reads that was never written
  task automatic queue_item(input in_item_t it);
    bit [3:0][31:0] taddr;
    int             n;
    int             t;
    in_item_t       ld;
    if (it.operation == OP_CUT) begin
      n = cut_corners(it, taddr);
      for (int i = 0; i < n; i++) begin
        t = int'(taddr[i]);
        if (!texel_loaded[t]) begin
          ld = rand_load();
          ld.frame_number = 8'(t / (MAX_MASK_SIDE * MAX_MASK_SIDE));
          ld.row = POS_W'((t / MAX_MASK_SIDE) % MAX_MASK_SIDE);
          ld.col = POS_W'(t % MAX_MASK_SIDE);
          texel_loaded[t] = 1'b1;
          items_to_send.push_back(ld);
          n_queued++;
        end
      end
    end else if (load_in_range(it)) begin
      texel_loaded[texel_index(int'(it.frame_number), int'(it.row), int'(it.col))] = 1'b1;
    end
    items_to_send.push_back(it);
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || pixels_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SOURCE_WIDTH:  src_w = value & ((1 << SRC_REG_W) - 1);
      REG_SOURCE_HEIGHT: src_h = value & ((1 << SRC_REG_W) - 1);
      REG_MASK_WIDTH:    msk_w = value & ((1 << MASK_REG_W) - 1);
      REG_MASK_HEIGHT:   msk_h = value & ((1 << MASK_REG_W) - 1);
      REG_FRAME_COUNT:   frame_cnt = value & ((1 << FC_REG_W) - 1);
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int unsigned sw, input int unsigned sh, input int unsigned mw,
                              input int unsigned mh, input int unsigned fc);
    write_reg(REG_SOURCE_WIDTH, sw);
    write_reg(REG_SOURCE_HEIGHT, sh);
    write_reg(REG_MASK_WIDTH, mw);
    write_reg(REG_MASK_HEIGHT, mh);
    write_reg(REG_FRAME_COUNT, fc);
  endtask

  // count covers every queued item, texel preloads included
  task automatic run_random(input int count, input int unsigned send_pct,
                            input int unsigned recv_pct, input bit pause_mid);
    int first;
    bit paused;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    first = n_queued;
    paused = 1'b0;
    while (n_queued - first < count) begin
      if (pause_mid && !paused && n_queued - first >= count / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(9) < 4) queue_item(rand_load());
      else queue_item(rand_cut());
    end
    wait_drained();
  endtask

  // run with the full-size geometry
  task automatic directed_items();
    in_item_t it;
    it = '0;
    it.operation = OP_LOAD;
    queue_item(it);
    // out-of-range loads must not alias onto the clear texel
    it.mask_alpha = 8'hFF;
    it.frame_number = 8'd8;
    queue_item(it);
    it.frame_number = 8'hFF;
    it.col = 10'h3FF;
    it.row = 10'h3FF;
    queue_item(it);
    it.frame_number = 8'd0;
    it.col = 10'd64;
    it.row = 10'd0;
    queue_item(it);
    it.col = 10'd0;
    it.row = 10'd64;
    queue_item(it);
    it.frame_number = 8'd7;
    it.col = 10'd63;
    it.row = 10'd63;
    queue_item(it);
    // four clear corners in frame 1
    it.mask_alpha = 8'd0;
    it.frame_number = 8'd1;
    for (int i = 0; i < 4; i++) begin
      it.col = POS_W'(i % 2);
      it.row = POS_W'(i / 2);
      queue_item(it);
    end
    it = '0;
    it.operation = OP_CUT;
    it.alpha = 8'hFF;
    it.red = 8'hFF;
    queue_item(it);
    it.frame_number = 8'hFF;
    it.col = 10'h3FF;
    it.row = 10'h3FF;
    it.green = 8'hFF;
    it.blue = 8'hFF;
    it.mask_alpha = 8'hFF;
    queue_item(it);
    it.frame_number = 8'd8;
    queue_item(it);
    it.frame_number = 8'd1;
    it.col = 10'd8;
    it.row = 10'd8;
    it.red = 8'h00;
    queue_item(it);
    it.frame_number = 8'd0;
    queue_item(it);
    it.row = 10'd0;
    queue_item(it);
    it.col = 10'd0;
    it.row = 10'd24;
    it.alpha = 8'd0;
    queue_item(it);
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    set_geometry(1024, 1024, 64, 64, 8);
    directed_items();
    run_random(120, 0, 0, 1'b0);

    set_geometry(0, 0, 0, 0, 0);
    run_random(60, 80, 0, 1'b0);

    set_geometry(2047, 2047, 127, 127, 15);
    run_random(100, 0, 80, 1'b0);

    set_geometry(7, 5, 3, 4, 3);
    run_random(180, 34, 34, 1'b1);

    set_geometry(1, 1, 64, 64, 8);
    run_random(100, 0, 0, 1'b0);

    set_geometry(640, 480, 17, 9, 2);
    run_random(150, 80, 0, 1'b0);

    set_geometry(33, 100, 64, 1, 1);
    run_random(100, 0, 80, 1'b0);

    set_geometry(1024, 1, 1, 64, 8);
    run_random(80, 34, 34, 1'b0);

    for (int p = 0; p < 3; p++) begin
      set_geometry($urandom_range(2047), $urandom_range(2047), $urandom_range(127),
                   $urandom_range(127), $urandom_range(15));
      run_random(80, (p == 0) ? 80 : ((p == 2) ? 34 : 0),
                 (p == 1) ? 80 : ((p == 2) ? 34 : 0), 1'b0);
    end

    if (n_errors == 0) begin
      $display("** bilinear_mask_alpha_cutout: PASSED **");
    end else begin
      $display("** bilinear_mask_alpha_cutout: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** bilinear_mask_alpha_cutout: FAILED **");
    $finish;
  end

endmodule
